### rtl/downsample_2x2_average_macros.svh
// ----------------------------------------------------------------------------
// downsample_2x2_average assertion macros
// shared concurrent assertion forms used across the pooling rtl
// ----------------------------------------------------------------------------
`ifndef DOWNSAMPLE_2X2_AVERAGE_MACROS_SVH
`define DOWNSAMPLE_2X2_AVERAGE_MACROS_SVH

// condition must hold at every edge outside reset
`define DSA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// shared types and constants of the 2x2 average pooling block
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int DIM_RESET   = 1024;
    localparam int QUEUE_DEPTH = 4;

    // store: park even-row pair sum, single: emit pair alone, combine: add parked sum
    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_SINGLE  = 2'd1,
        OP_COMBINE = 2'd2
    } t_op;

    typedef struct packed {
        t_op  op;
        logic hshift;
        logic row_end;
        logic image_end;
    } t_cmd_ctl;

    localparam int CMD_CTL_BITS = $bits(t_cmd_ctl);

endpackage

### rtl/downsample_2x2_average.sv
// ----------------------------------------------------------------------------
// downsample_2x2_average
// path of a completed block: queue write, buffer read, output register
// throughput: one pixel per cycle while full is low, set by the
//   single-port half-row buffer
// reset: synchronous active low; position restarts at row 0, size 1024 x 1024
// ----------------------------------------------------------------------------
module downsample_2x2_average #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [PIXEL_BITS-1:0]       i_pixel,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [PIXEL_BITS-1:0]       o_average,
    output logic                               o_row_end,
    output logic                               o_image_end,
    input  logic                               i_cfg_we,
    input  logic [dsa_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dsa_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int SUM_BITS   = PIXEL_BITS + 1;
    localparam int HALF_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_BITS  = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CTL_BITS   = dsa_pkg::CMD_CTL_BITS;
    localparam int Q_BITS     = CTL_BITS + ADDR_BITS + SUM_BITS;

    logic                       cmd_push;
    dsa_pkg::t_cmd_ctl          cmd_ctl;
    logic [ADDR_BITS-1:0]       cmd_addr;
    logic signed [SUM_BITS-1:0] cmd_sum;

    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    logic [Q_BITS-1:0]          q_wr_data;
    logic [Q_BITS-1:0]          q_rd_data;
    dsa_pkg::t_cmd_ctl          q_ctl;
    logic [ADDR_BITS-1:0]       q_addr;
    logic signed [SUM_BITS-1:0] q_sum;

    dsa_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd_ctl   (cmd_ctl),
        .o_cmd_addr  (cmd_addr),
        .o_cmd_sum   (cmd_sum)
    );

    assign q_wr_data = {cmd_ctl, cmd_addr, cmd_sum};

    dsa_queue #(
        .DATA_BITS (Q_BITS),
        .DEPTH     (dsa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    assign q_ctl  = q_rd_data[Q_BITS-1 -: CTL_BITS];
    assign q_addr = q_rd_data[SUM_BITS +: ADDR_BITS];
    assign q_sum  = q_rd_data[SUM_BITS-1:0];

    dsa_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .HALF_DEPTH (HALF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd_ctl   (q_ctl),
        .i_cmd_addr  (q_addr),
        .i_cmd_sum   (q_sum),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_average   (o_average),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end)
    );

    // the front takes a pixel only while the command queue has room
    assign full = q_full;

endmodule

### rtl/dsa_front.sv
// ----------------------------------------------------------------------------
// dsa_front
// tracks raster position, forms horizontal pair sums and issues block commands
// ----------------------------------------------------------------------------
module dsa_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int ADDR_BITS  = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_q_full,
    input  logic signed [PIXEL_BITS-1:0]          i_pixel,
    input  logic                                  i_cfg_we,
    input  logic [dsa_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [dsa_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic                                  o_cmd_push,
    output dsa_pkg::t_cmd_ctl                     o_cmd_ctl,
    output logic [ADDR_BITS-1:0]                  o_cmd_addr,
    output logic signed [PIXEL_BITS:0]            o_cmd_sum
);

    localparam int SUM_BITS = PIXEL_BITS + 1;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS = dsa_pkg::CFG_DATA_BITS;
    localparam int MAX_POS  = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int CMP_W    = ((MAX_POS > DIM_BITS) ? MAX_POS : DIM_BITS) + 1;
    localparam int W_RESET  = (MAX_WIDTH < dsa_pkg::DIM_RESET) ? MAX_WIDTH
                                                               : dsa_pkg::DIM_RESET;
    localparam int H_RESET  = (MAX_HEIGHT < dsa_pkg::DIM_RESET) ? MAX_HEIGHT
                                                                : dsa_pkg::DIM_RESET;

    logic [COL_BITS-1:0]        r_col;
    logic [ROW_BITS-1:0]        r_row;
    logic signed [SUM_BITS-1:0] r_pair_sum;
    logic [DIM_BITS-1:0]        r_width;
    logic [DIM_BITS-1:0]        r_height;

    logic                       accept;
    logic                       col_odd;
    logic                       last_col;
    logic                       last_row;
    logic signed [SUM_BITS-1:0] pix_ext;
    logic signed [SUM_BITS-1:0] n_pair_sum;

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input int max_dim);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (int'(v) > max_dim) begin
            res = DIM_BITS'(max_dim);
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_comb begin
        accept     = i_push && !i_q_full;
        col_odd    = r_col[0];
        last_col   = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(r_width);
        last_row   = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(r_height);
        pix_ext    = {i_pixel[PIXEL_BITS-1], i_pixel};
        n_pair_sum = col_odd ? (r_pair_sum + pix_ext) : pix_ext;

        o_cmd_push           = accept && (col_odd || last_col);
        o_cmd_ctl.hshift     = col_odd;
        o_cmd_ctl.row_end    = last_col;
        o_cmd_ctl.image_end  = last_col && last_row;
        if (r_row[0]) begin
            o_cmd_ctl.op = dsa_pkg::OP_COMBINE;
        end else if (last_row) begin
            o_cmd_ctl.op = dsa_pkg::OP_SINGLE;
        end else begin
            o_cmd_ctl.op = dsa_pkg::OP_STORE;
        end
        o_cmd_addr = ADDR_BITS'(r_col >> 1);
        o_cmd_sum  = n_pair_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pair_sum <= '0;
            r_width    <= DIM_BITS'(W_RESET);
            r_height   <= DIM_BITS'(H_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dsa_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= clamp_dim(i_cfg_data, MAX_WIDTH);
                end
                dsa_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= clamp_dim(i_cfg_data, MAX_HEIGHT);
                end
                default: begin
                end
            endcase
            // any register write restarts the image
            r_col      <= '0;
            r_row      <= '0;
            r_pair_sum <= '0;
        end else if (accept) begin
            r_pair_sum <= n_pair_sum;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : (r_row + ROW_BITS'(1));
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

endmodule

### rtl/dsa_queue.sv
// ----------------------------------------------------------------------------
// dsa_queue
// small first-in first-out command queue between front and back
// ----------------------------------------------------------------------------
`include "downsample_2x2_average_macros.svh"

module dsa_queue #(
    parameter int DATA_BITS = 32,
    parameter int DEPTH     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output logic                 o_empty
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  r_slot [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [COUNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_full  = (r_count == COUNT_BITS'(DEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_slot[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : (r_wr_ptr + PTR_BITS'(1));
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : (r_rd_ptr + PTR_BITS'(1));
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + COUNT_BITS'(1);
                2'b01:   r_count <= r_count - COUNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `DSA_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= COUNT_BITS'(DEPTH), "queue count past depth")
    `DSA_ASSERT_NEXT(a_full_blocks, i_clk, i_rst_n, o_full && !i_pop, o_full && $stable(r_wr_ptr), "queue written while full")

endmodule

### rtl/dsa_back.sv
// ----------------------------------------------------------------------------
// dsa_back
// half-row sum buffer, block sum, floor shift and output register
// ----------------------------------------------------------------------------
`include "downsample_2x2_average_macros.svh"

module dsa_back #(
    parameter int PIXEL_BITS = 16,
    parameter int ADDR_BITS  = 9,
    parameter int HALF_DEPTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  dsa_pkg::t_cmd_ctl            i_cmd_ctl,
    input  logic [ADDR_BITS-1:0]         i_cmd_addr,
    input  logic signed [PIXEL_BITS:0]   i_cmd_sum,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [PIXEL_BITS-1:0] o_average,
    output logic                         o_row_end,
    output logic                         o_image_end
);

    localparam int SUM_BITS = PIXEL_BITS + 1;

    logic [SUM_BITS-1:0]          r_mem [HALF_DEPTH];
    logic signed [SUM_BITS-1:0]   r_rd_data;
    logic                         r_s1_valid;
    dsa_pkg::t_cmd_ctl            r_s1_ctl;
    logic signed [SUM_BITS-1:0]   r_s1_sum;
    logic                         r_out_valid;
    logic signed [PIXEL_BITS-1:0] r_out_avg;
    logic                         r_out_row_end;
    logic                         r_out_image_end;

    logic                         s1_move;
    logic                         take;
    logic                         take_store;
    logic signed [SUM_BITS:0]     total;
    logic [1:0]                   shift;
    logic signed [SUM_BITS:0]     shifted;

    always_comb begin
        s1_move    = r_s1_valid && (!r_out_valid || i_pop);
        take       = !i_q_empty && (!r_s1_valid || s1_move);
        take_store = take && (i_cmd_ctl.op == dsa_pkg::OP_STORE);
        o_q_pop    = take;

        case (r_s1_ctl.op)
            dsa_pkg::OP_COMBINE: begin
                total = {r_rd_data[SUM_BITS-1], r_rd_data} + {r_s1_sum[SUM_BITS-1], r_s1_sum};
                shift = {1'b0, r_s1_ctl.hshift} + 2'd1;
            end
            default: begin
                total = {r_s1_sum[SUM_BITS-1], r_s1_sum};
                shift = {1'b0, r_s1_ctl.hshift};
            end
        endcase
        // arithmetic shift gives the floor of the division by 1, 2 or 4
        shifted = total >>> shift;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (take_store) begin
                r_mem[i_cmd_addr] <= i_cmd_sum;
            end else begin
                r_rd_data <= r_mem[i_cmd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !take_store) begin
            r_s1_ctl <= i_cmd_ctl;
            r_s1_sum <= i_cmd_sum;
        end
        if (s1_move) begin
            r_out_avg       <= shifted[PIXEL_BITS-1:0];
            r_out_row_end   <= r_s1_ctl.row_end;
            r_out_image_end <= r_s1_ctl.image_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= !take_store;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_average   = r_out_avg;
    assign o_row_end   = r_out_row_end;
    assign o_image_end = r_out_image_end;

    `DSA_ASSERT_ALWAYS(a_no_store_in_s1, i_clk, i_rst_n, !r_s1_valid || r_s1_ctl.op != dsa_pkg::OP_STORE, "store command reached compute stage")
    `DSA_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, s1_move, r_out_valid, "compute stage result lost")
    `DSA_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && r_out_valid && !i_pop, r_s1_valid && $stable(r_s1_sum), "compute stage changed under stall")

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// 2x2 average pooling: a directed table, a long receiver hold, then random
// image sizes and pixels. Every result is checked against a typed expected
// value or a behavioral pooling model; random parts add gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_DIM      = 1024;
    localparam int HALF_DEPTH   = MAX_DIM / 2;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 340;
    localparam int IMAGE_CAP    = 96;

    typedef struct packed {
        logic signed [15:0] average;
        logic               row_end;
        logic               image_end;
    } t_pool_result;

    typedef enum logic {ROW_CFG, ROW_PIXEL} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [dsa_pkg::CFG_INDEX_BITS-1:0] index;
        logic [15:0]                        value;
        logic                               typed;
        t_pool_result                       want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 27;

    // pixel rows with a typed result carry it in want, the rest go to the model
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_WIDTH,  16'd2,    1'b0, '0},
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_HEIGHT, 16'd2,    1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h7FFF, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h7FFF, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h7FFF, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h7FFF, 1'b1, '{16'sh7FFF, 1'b1, 1'b1}},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h8000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h8000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h8000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h8000, 1'b1, '{16'sh8000, 1'b1, 1'b1}},
        // zero size acts as one: every pixel is its own block
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_WIDTH,  16'd0,    1'b0, '0},
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_HEIGHT, 16'd0,    1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'hFFFF, 1'b1, '{16'shFFFF, 1'b1, 1'b1}},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0001, 1'b1, '{16'sh0001, 1'b1, 1'b1}},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h5A5A, 1'b1, '{16'sh5A5A, 1'b1, 1'b1}},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'hA5A5, 1'b1, '{16'shA5A5, 1'b1, 1'b1}},
        // odd sizes: edge pairs, a lone last row and a single corner pixel
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_WIDTH,  16'd3,    1'b0, '0},
        '{ROW_CFG,   dsa_pkg::CFG_IMAGE_HEIGHT, 16'd3,    1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'hFFFF, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'hFFFD, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0000, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0005, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'hFFFE, 1'b0, '0},
        '{ROW_PIXEL, dsa_pkg::CFG_IMAGE_WIDTH,  16'h0007, 1'b0, '0}
    };

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               push        = 1'b0;
    logic                               pop         = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic signed [15:0]                 i_pixel     = '0;
    logic [dsa_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [dsa_pkg::CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                               full;
    logic                               empty;
    logic                               o_row_end;
    logic                               o_image_end;
    logic signed [15:0]                 o_average;

    // pooling model state
    int                 img_width  = dsa_pkg::DIM_RESET;
    int                 img_height = dsa_pkg::DIM_RESET;
    int                 col_pos    = 0;
    int                 row_pos    = 0;
    logic signed [16:0] pair_sum   = '0;
    logic signed [16:0] half_sums [HALF_DEPTH];
    t_pool_result       pending_averages [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    always #5 i_clk = ~i_clk;

    downsample_2x2_average u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_average   (o_average),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic void pool_config(input logic [dsa_pkg::CFG_INDEX_BITS-1:0] idx,
                                        input logic [dsa_pkg::CFG_DATA_BITS-1:0] val);
        int dim;
        dim = (val == 0) ? 1 : (val > MAX_DIM) ? MAX_DIM : int'(val);
        if (idx == dsa_pkg::CFG_IMAGE_WIDTH) begin
            img_width = dim;
        end else begin
            img_height = dim;
        end
        col_pos  = 0;
        row_pos  = 0;
        pair_sum = '0;
    endfunction

    function automatic bit pool_pixel(input logic signed [15:0] pix,
                                      output t_pool_result res);
        bit                 last_col;
        bit                 last_row;
        bit                 odd_col;
        bit                 produced;
        logic signed [17:0] total;
        int                 slot;
        last_col = (col_pos + 1 >= img_width);
        last_row = (row_pos + 1 >= img_height);
        odd_col  = (col_pos % 2 == 1);
        slot     = col_pos / 2;
        produced = 1'b0;
        res      = '0;
        total    = '0;
        if (odd_col) begin
            pair_sum = pair_sum + pix;
        end else begin
            pair_sum = pix;
        end
        if (odd_col || last_col) begin
            if (row_pos % 2 == 0 && !last_row) begin
                half_sums[slot] = pair_sum;
            end else begin
                // odd row adds the parked even-row sum, a lone last row stands alone
                if (row_pos % 2 == 1) begin
                    total = half_sums[slot] + pair_sum;
                    total = total >>> 1;
                end else begin
                    total = pair_sum;
                end
                if (odd_col) begin
                    total = total >>> 1;
                end
                res.average   = total[15:0];
                res.row_end   = last_col;
                res.image_end = last_col && last_row;
                produced      = 1'b1;
            end
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return produced;
    endfunction

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [dsa_pkg::CFG_DATA_BITS-1:0] rand_dim();
        if ($urandom_range(7) == 0) begin
            return dsa_pkg::CFG_DATA_BITS'($urandom_range(10, 40));
        end
        return dsa_pkg::CFG_DATA_BITS'($urandom_range(1, 9));
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic send_pixel(input logic signed [15:0] pix, input bit typed,
                              input t_pool_result want);
        t_pool_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (full);
        if (pool_pixel(pix, res)) begin
            pending_averages.push_back(typed ? want : res);
        end
    endtask

    // wait for every pending result, then for the pipeline to empty
    task automatic settle();
        push <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [dsa_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [dsa_pkg::CFG_DATA_BITS-1:0] val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_config(idx, val);
    endtask

    always @(posedge i_clk) begin
        t_pool_result want;
        if (pop && !empty) begin
            if (pending_averages.size() == 0) begin
                flag_error($sformatf("unexpected result, average %0d", o_average));
            end else begin
                want = pending_averages.pop_front();
                if (o_average !== want.average)
                    flag_error($sformatf("average %0d, expected %0d", o_average,
                                         want.average));
                if (o_row_end !== want.row_end)
                    flag_error($sformatf("row_end %b, expected %b", o_row_end,
                                         want.row_end));
                if (o_image_end !== want.image_end)
                    flag_error($sformatf("image_end %b, expected %b", o_image_end,
                                         want.image_end));
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("downsample_2x2_average test failed");
            $finish;
        end
    end

    initial begin
        t_pool_result none;
        int           rand_items;
        int           phase;
        int           pixels;
        int           mode;
        none       = '0;
        rand_items = 0;
        phase      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                cfg_write(directed_rows[i].index,
                          directed_rows[i].value[dsa_pkg::CFG_DATA_BITS-1:0]);
            end else begin
                send_pixel(directed_rows[i].value, directed_rows[i].typed,
                           directed_rows[i].want);
            end
        end

        // receiver holds off so the block fills and pushes back
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_write(dsa_pkg::CFG_IMAGE_WIDTH, 11'd1);
        cfg_write(dsa_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        hold_left = 120;
        repeat (40) send_pixel(rand_pixel(), 1'b0, none);

        while (rand_items < RANDOM_ITEMS) begin
            mode           = phase % 4;
            send_idle_pct  = (mode == 1) ? 75 : (mode == 3) ? 12 : 0;
            recv_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 12 : 0;
            cfg_write(dsa_pkg::CFG_IMAGE_WIDTH, rand_dim());
            cfg_write(dsa_pkg::CFG_IMAGE_HEIGHT, rand_dim());
            // mostly whole images, sometimes two back to back or one cut short
            pixels = img_width * img_height;
            case ($urandom_range(3))
                0: pixels = $urandom_range(1, pixels);
                1: pixels = 2 * pixels;
                default: ;
            endcase
            if (pixels > IMAGE_CAP) begin
                pixels = IMAGE_CAP;
            end
            for (int n = 0; n < pixels; n++) begin
                if (phase % 5 == 2 && n == pixels / 2) begin
                    settle();
                end
                send_pixel(rand_pixel(), 1'b0, none);
                rand_items++;
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0) begin
            $display("downsample_2x2_average test passed");
        end else begin
            $display("downsample_2x2_average test failed");
        end
        $finish;
    end

endmodule
